>>> src/acbm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the arrival curve burst meter.
// No dependencies; used by acbm_if, the top and the checker, not by acbm_ram.
package acbm_pkg;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int NUM_WINDOWS_DEF = 7;
  localparam int MAX_WIN         = 7;
  localparam int STAMP_W         = 48;
  localparam int LEN_W           = 32;
  localparam int COUNT_W         = 11;
  localparam int WIN_IDX_W       = 3;
  localparam int PADDR_W         = 5;
  localparam int PDATA_W         = 32;

  localparam logic [LEN_W-1:0] LEN_RESET [MAX_WIN] = '{
    32'd1000, 32'd4000, 32'd16000, 32'd64000, 32'd256000, 32'd1024000, 32'd4096000
  };

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_OVF_RD  = 7'b0000010,
    S_OVF_CMP = 7'b0000100,
    S_WRITE   = 7'b0001000,
    S_WIN_RD  = 7'b0010000,
    S_WIN_CMP = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

endpackage

>>> src/acbm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for stamps in and peak reports out.
// Depends on acbm_pkg.
interface acbm_stamp_if import acbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] stamp;
  logic               restart;
  logic               batch_last;
  modport source (output valid, stamp, restart, batch_last, input ready);
  modport sink (input valid, stamp, restart, batch_last, output ready);
endinterface

interface acbm_peak_if import acbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] peak_count_0;
  logic [COUNT_W-1:0] peak_count_1;
  logic [COUNT_W-1:0] peak_count_2;
  logic [COUNT_W-1:0] peak_count_3;
  logic [COUNT_W-1:0] peak_count_4;
  logic [COUNT_W-1:0] peak_count_5;
  logic [COUNT_W-1:0] peak_count_6;
  logic               curve_rose;
  logic               count_saturated;
  modport source (output valid, peak_count_0, peak_count_1, peak_count_2, peak_count_3,
                  peak_count_4, peak_count_5, peak_count_6, curve_rose, count_saturated,
                  input ready);
  modport sink (input valid, peak_count_0, peak_count_1, peak_count_2, peak_count_3,
                peak_count_4, peak_count_5, peak_count_6, curve_rose, count_saturated,
                output ready);
endinterface

>>> src/acbm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acbm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/arrival_curve_burst_meter_top.sv
`timescale 1ns / 1ps
// Each stamp runs an overflow pass over the window tails when the ring is full, then the
// ring write, then a read and compare loop per window; one shared 48-bit add and compare.
// Throughput: one transaction at a time; the next stamp is taken in the cycle after the
// report is accepted.
// Reset (rst, synchronous, active high) clears history, peaks and sets the window
// lengths to their defaults. The stamp ring itself is never cleared.
module arrival_curve_burst_meter_top import acbm_pkg::*; #(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int NUM_WINDOWS = NUM_WINDOWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  acbm_stamp_if.sink         stamp_in,
  acbm_peak_if.source        peak_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
  localparam logic [WIN_IDX_W-1:0] LAST_WIN = WIN_IDX_W'(NUM_WINDOWS - 1);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // Window length registers, written over the APB port.
  logic [LEN_W-1:0] window_len [MAX_WIN];
  logic [WIN_IDX_W-1:0] reg_idx;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WIN; i++) window_len[i] <= LEN_RESET[i];
    end else if (psel && penable && pwrite && (int'(reg_idx) < MAX_WIN)) begin
      window_len[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (int'(reg_idx) < MAX_WIN) prdata = window_len[reg_idx];
  end

  // Sequencer state and history.
  state_t state;
  logic [AW-1:0]        write_slot;
  logic [AW-1:0]        slot_new;
  logic [CW-1:0]        fill_level;
  logic [STAMP_W-1:0]   newest_stamp;
  logic [STAMP_W-1:0]   cur_stamp;
  logic                 cur_last;
  logic [AW-1:0]        tail_slot [MAX_WIN];
  logic [CW-1:0]        peak_store [MAX_WIN];
  logic                 rose_pending;
  logic                 saturated;
  logic [WIN_IDX_W-1:0] widx;

  // Stamp ring: one write port, one registered read port.
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [STAMP_W-1:0]   ram_rdata;

  acbm_ram #(.WIDTH(STAMP_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (cur_stamp),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we = (state == S_WRITE);
  assign ram_raddr = (state == S_OVF_RD || state == S_OVF_CMP) ? write_slot : tail_slot[widx];

  // The shared unit: is the stored stamp plus the current length still at or
  // below the new stamp, i.e. has the entry dropped out of the window?
  logic [STAMP_W:0] sum;
  logic             expired;
  assign sum = {1'b0, ram_rdata} + {{(STAMP_W + 1 - LEN_W){1'b0}}, window_len[widx]};
  assign expired = (sum <= {1'b0, cur_stamp});

  // Entries from the current tail up to and including the newest stamp.
  logic [AW-1:0] cur_tail;
  logic [CW-1:0] win_count;
  assign cur_tail = tail_slot[widx];
  always_comb begin
    if (write_slot > cur_tail) begin
      win_count = {1'b0, write_slot - cur_tail};
    end else begin
      win_count = DEPTH_C - {1'b0, cur_tail - write_slot};
    end
  end

  // Accept-time view of history, taking a restart into account.
  logic               accept;
  logic [CW-1:0]      fill_eff;
  logic [STAMP_W-1:0] stamp_eff;
  assign accept = stamp_in.valid && stamp_in.ready;
  assign fill_eff = stamp_in.restart ? '0 : fill_level;
  always_comb begin
    stamp_eff = stamp_in.stamp;
    if (fill_eff != '0 && stamp_in.stamp < newest_stamp) stamp_eff = newest_stamp;
  end

  logic finish_win;
  assign finish_win = (state == S_WIN_RD && cur_tail == slot_new) ||
                      (state == S_WIN_CMP && !expired);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      fill_level   <= '0;
      newest_stamp <= '0;
      rose_pending <= 1'b0;
      saturated    <= 1'b0;
      widx         <= '0;
      for (int i = 0; i < MAX_WIN; i++) begin
        tail_slot[i]  <= '0;
        peak_store[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (stamp_in.restart) begin
              write_slot   <= '0;
              fill_level   <= '0;
              newest_stamp <= '0;
              rose_pending <= 1'b0;
              for (int i = 0; i < MAX_WIN; i++) begin
                tail_slot[i]  <= '0;
                peak_store[i] <= '0;
              end
            end
            cur_stamp <= stamp_eff;
            cur_last  <= stamp_in.batch_last;
            saturated <= 1'b0;
            widx      <= '0;
            state     <= (fill_eff >= DEPTH_C) ? S_OVF_RD : S_WRITE;
          end
        end
        S_OVF_RD: begin
          state <= S_OVF_CMP;
        end
        S_OVF_CMP: begin
          // The slot about to be overwritten leaves every window whose tail sits on it.
          if (cur_tail == write_slot) begin
            if (!expired) saturated <= 1'b1;
            tail_slot[widx] <= next_slot(write_slot);
          end
          if (widx == LAST_WIN) begin
            widx  <= '0;
            state <= S_WRITE;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        S_WRITE: begin
          slot_new     <= write_slot;
          write_slot   <= next_slot(write_slot);
          newest_stamp <= cur_stamp;
          if (fill_level < DEPTH_C) fill_level <= fill_level + 1'b1;
          widx  <= '0;
          state <= S_WIN_RD;
        end
        S_WIN_RD: begin
          if (!finish_win) state <= S_WIN_CMP;
        end
        S_WIN_CMP: begin
          if (expired) begin
            tail_slot[widx] <= next_slot(cur_tail);
            state <= S_WIN_RD;
          end
        end
        S_OUT: begin
          if (peak_out.ready) begin
            if (cur_last) rose_pending <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (finish_win) begin
        if (win_count > peak_store[widx]) begin
          peak_store[widx] <= win_count;
          rose_pending <= 1'b1;
        end
        if (widx == LAST_WIN) begin
          widx  <= '0;
          state <= S_OUT;
        end else begin
          widx  <= widx + 1'b1;
          state <= S_WIN_RD;
        end
      end
    end
  end

  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
    logic [CW+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, c};
    to_count = wide[COUNT_W-1:0];
  endfunction

  assign stamp_in.ready          = (state == S_IDLE);
  assign peak_out.valid          = (state == S_OUT);
  assign peak_out.peak_count_0   = to_count(peak_store[0]);
  assign peak_out.peak_count_1   = to_count(peak_store[1]);
  assign peak_out.peak_count_2   = to_count(peak_store[2]);
  assign peak_out.peak_count_3   = to_count(peak_store[3]);
  assign peak_out.peak_count_4   = to_count(peak_store[4]);
  assign peak_out.peak_count_5   = to_count(peak_store[5]);
  assign peak_out.peak_count_6   = to_count(peak_store[6]);
  assign peak_out.curve_rose     = rose_pending;
  assign peak_out.count_saturated = saturated;
endmodule

>>> src/acbm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the burst meter and the bind that attaches them.
// Depends on acbm_pkg and arrival_curve_burst_meter_top.
module acbm_checker import acbm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               restart,
  input logic [COUNT_W-1:0] peak0
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while a report is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after a transaction");

  a_report_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(peak0)) else $error("report dropped");

  a_restart_peak: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && restart |=> peak0 == '0) else $error("restart kept a peak");
endmodule

bind arrival_curve_burst_meter_top acbm_checker u_acbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stamp_in.valid),
  .in_ready  (stamp_in.ready),
  .out_valid (peak_out.valid),
  .out_ready (peak_out.ready),
  .restart   (stamp_in.restart),
  .peak0     (peak_out.peak_count_0)
);
